>>> rtl/mcat_pkg.sv
// Shared types and constants for the multi-channel alarm timer.
// Used by rtl/multi_channel_alarm_timer.sv; depends on nothing else.

package mcat_pkg;

   localparam int CHANNELS     = 16;
   localparam int CHAN_W       = 4;
   localparam int CNT_W        = CHAN_W + 1;
   localparam int CMD_W        = 3;
   localparam int IVL_W        = 31;
   localparam int TIME_W       = 32;
   localparam int ELAPSED_W    = 16;
   localparam int UPD_W        = 16;

   localparam logic [UPD_W-1:0]  UPDATE_INTERVAL_RESET = 16'd20;
   localparam logic [TIME_W-1:0] REBASE_LIMIT          = 32'd2000000000;

   localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CREATE     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET_ACTIVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ACK        = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd4;

   // One entry of the channel table memory.
   typedef struct packed {
      logic [IVL_W-1:0]  interval;
      logic [TIME_W-1:0] due_time;
   } chan_entry_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXEC   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_LOOKUP = 5'b01000,
      ST_REPORT = 5'b10000
   } state_type;

endpackage

>>> rtl/multi_channel_alarm_timer.sv
// Top level of the multi-channel alarm timer: command decode, tick scan over the channel
// table memory, and the report. Depends on rtl/mcat_pkg.sv.

// A transaction is taken when start is high and busy is low, and its single report appears
// on the rsp_ ports for one cycle with rsp_valid high; the receiver cannot stall it, so it
// must capture every report as it appears. Create, set active, acknowledge, delete and
// unknown commands keep busy high through the exec, lookup and report states, with the
// report in the cycle after. A tick keeps busy high through the exec state (time update),
// the scan state (all 16 channel table entries streamed through the table memory: read,
// rebase, update and write back, one entry per cycle, then a pipeline drain) and the lookup
// and report states for the addressed channel. The next transaction can be started in the
// cycle that shows the report. The update interval may be written only while busy is low.

module multi_channel_alarm_timer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [mcat_pkg::CMD_W-1:0]       req_command,
   input  logic [mcat_pkg::CHAN_W-1:0]      req_channel,
   input  logic [mcat_pkg::IVL_W-1:0]       req_interval_ms,
   input  logic                             req_active_flag,
   input  logic [mcat_pkg::ELAPSED_W-1:0]   req_elapsed_ms,
   output logic                             rsp_valid,
   output logic [mcat_pkg::CHANNELS-1:0]    rsp_alarm_mask,
   output logic                             rsp_chan_alarming,
   output logic                             rsp_chan_active,
   output logic signed [mcat_pkg::TIME_W-1:0] rsp_time_left,
   output logic [mcat_pkg::TIME_W-1:0]      rsp_system_time,
   input  logic                             csr_wr_en,
   input  logic [mcat_pkg::UPD_W-1:0]       csr_wr_data
);

   // Control state.
   mcat_pkg::state_type state_ff, state_in;
   logic [mcat_pkg::UPD_W-1:0]     update_interval_ff;
   logic [mcat_pkg::TIME_W-1:0]    sys_ff, sys_in;
   logic [mcat_pkg::ELAPSED_W-1:0] pending_ff, pending_in;
   logic [mcat_pkg::CHANNELS-1:0]  valid_ff, valid_in;
   logic [mcat_pkg::CHANNELS-1:0]  enable_ff, enable_in;
   logic [mcat_pkg::CHANNELS-1:0]  ack_ff, ack_in;
   logic [mcat_pkg::CHANNELS-1:0]  alarm_ff, alarm_in;
   logic [mcat_pkg::CNT_W-1:0]     scan_cnt_ff, scan_cnt_in;
   logic                           s1_vld_ff, s1_vld_in;
   logic                           s2_vld_ff;
   logic                           rebase_ff, rebase_in;
   logic                           rsp_valid_ff;

   // Latched transaction payload.
   logic [mcat_pkg::CMD_W-1:0]     cmd_ff;
   logic [mcat_pkg::CHAN_W-1:0]    ch_ff;
   logic [mcat_pkg::IVL_W-1:0]     ivl_ff;
   logic                           act_ff;
   logic [mcat_pkg::ELAPSED_W-1:0] el_ff;
   logic [mcat_pkg::TIME_W-1:0]    rebase_sub_ff;

   // Scan pipeline payload.
   logic [mcat_pkg::CHAN_W-1:0]    s1_addr_ff;
   logic [mcat_pkg::CHAN_W-1:0]    s2_addr_ff;
   logic [mcat_pkg::IVL_W-1:0]     s2_ivl_ff;
   logic [mcat_pkg::TIME_W-1:0]    s2_due_ff, s2_due_in;

   // Channel table memory.
   mcat_pkg::chan_entry_type       mem [mcat_pkg::CHANNELS];
   mcat_pkg::chan_entry_type       mem_q_ff;
   mcat_pkg::chan_entry_type       mem_wd;
   logic [mcat_pkg::CHAN_W-1:0]    mem_ra;
   logic [mcat_pkg::CHAN_W-1:0]    mem_wa;
   logic                           mem_we;

   // Response registers.
   logic [mcat_pkg::CHANNELS-1:0]  rsp_mask_ff;
   logic                           rsp_alarming_ff;
   logic                           rsp_active_ff;
   logic [mcat_pkg::TIME_W-1:0]    rsp_left_ff, rsp_left_in;
   logic [mcat_pkg::TIME_W-1:0]    rsp_sys_ff;

   logic                           accept;
   logic                           ch_inside;
   logic                           ch_valid;
   logic                           rebase_now;
   logic [mcat_pkg::ELAPSED_W:0]   pending_sum;
   logic [mcat_pkg::TIME_W-1:0]    sys_base;
   logic [mcat_pkg::TIME_W-1:0]    s1_due;
   logic                           s2_live;
   logic [mcat_pkg::TIME_W:0]      left_diff;

   assign accept     = start && (state_ff == mcat_pkg::ST_IDLE);
   assign ch_inside  = {1'b0, ch_ff} < mcat_pkg::CNT_W'(mcat_pkg::CHANNELS);
   assign ch_valid   = ch_inside && valid_ff[ch_ff];
   assign s2_live    = s2_vld_ff && valid_ff[s2_addr_ff];

   // Time update for a tick: rebase on the old time, then fold in the pending count.
   assign rebase_now  = sys_ff >= mcat_pkg::REBASE_LIMIT;
   assign sys_base    = rebase_now ? '0 : sys_ff;
   assign pending_sum = {1'b0, pending_ff} + {1'b0, el_ff};

   always_comb begin
      state_in    = state_ff;
      sys_in      = sys_ff;
      pending_in  = pending_ff;
      rebase_in   = rebase_ff;
      scan_cnt_in = scan_cnt_ff;
      s1_vld_in   = 1'b0;
      unique case (state_ff)
         mcat_pkg::ST_IDLE: begin
            if (start) begin
               state_in = mcat_pkg::ST_EXEC;
            end
         end
         mcat_pkg::ST_EXEC: begin
            if (cmd_ff == mcat_pkg::CMD_TICK) begin
               rebase_in   = rebase_now;
               scan_cnt_in = '0;
               state_in    = mcat_pkg::ST_SCAN;
               if (pending_sum >= {1'b0, update_interval_ff}) begin
                  sys_in     = sys_base + mcat_pkg::TIME_W'(pending_sum);
                  pending_in = '0;
               end else begin
                  sys_in     = sys_base;
                  pending_in = pending_sum[mcat_pkg::ELAPSED_W-1:0];
               end
            end else begin
               state_in = mcat_pkg::ST_LOOKUP;
            end
         end
         mcat_pkg::ST_SCAN: begin
            if (scan_cnt_ff != mcat_pkg::CNT_W'(mcat_pkg::CHANNELS)) begin
               s1_vld_in   = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end else if (!s1_vld_ff) begin
               // The last entry is written back at this edge, before the lookup read.
               state_in = mcat_pkg::ST_LOOKUP;
            end
         end
         mcat_pkg::ST_LOOKUP: begin
            state_in = mcat_pkg::ST_REPORT;
         end
         mcat_pkg::ST_REPORT: begin
            state_in = mcat_pkg::ST_IDLE;
         end
         default: begin
            state_in = mcat_pkg::ST_IDLE;
         end
      endcase
   end

   // Rebase stage: armed entries move down by the old system time, saturating at one.
   always_comb begin
      s1_due = mem_q_ff.due_time;
      if (rebase_ff && (mem_q_ff.due_time != '0)) begin
         if (mem_q_ff.due_time > rebase_sub_ff) begin
            s1_due = mem_q_ff.due_time - rebase_sub_ff;
         end else begin
            s1_due = mcat_pkg::TIME_W'(1);
         end
      end
   end

   // Flag updates from commands and from the scan's update stage.
   always_comb begin
      valid_in  = valid_ff;
      enable_in = enable_ff;
      ack_in    = ack_ff;
      alarm_in  = alarm_ff;
      s2_due_in = s2_due_ff;
      if (state_ff == mcat_pkg::ST_EXEC) begin
         unique case (cmd_ff)
            mcat_pkg::CMD_CREATE: begin
               if (ch_inside) begin
                  valid_in[ch_ff]  = 1'b1;
                  enable_in[ch_ff] = act_ff;
                  alarm_in[ch_ff]  = 1'b0;
                  ack_in[ch_ff]    = 1'b0;
               end
            end
            mcat_pkg::CMD_SET_ACTIVE: begin
               if (ch_valid) begin
                  enable_in[ch_ff] = act_ff;
               end
            end
            mcat_pkg::CMD_ACK: begin
               if (ch_valid) begin
                  ack_in[ch_ff] = 1'b1;
               end
            end
            mcat_pkg::CMD_DELETE: begin
               if (ch_valid) begin
                  valid_in[ch_ff]  = 1'b0;
                  enable_in[ch_ff] = 1'b0;
                  alarm_in[ch_ff]  = 1'b0;
                  ack_in[ch_ff]    = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end else if (s2_live) begin
         // A due time of zero means the channel is not armed yet.
         if (s2_due_ff == '0) begin
            s2_due_in = {1'b0, s2_ivl_ff} + sys_ff;
         end else if ((sys_ff >= s2_due_ff) && !ack_ff[s2_addr_ff]
                      && enable_ff[s2_addr_ff]) begin
            alarm_in[s2_addr_ff] = 1'b1;
         end else if (ack_ff[s2_addr_ff]) begin
            alarm_in[s2_addr_ff] = 1'b0;
            ack_in[s2_addr_ff]   = 1'b0;
            s2_due_in            = '0;
         end
      end
   end

   // Table memory port selection.
   always_comb begin
      mem_ra = (state_ff == mcat_pkg::ST_SCAN) ? scan_cnt_ff[mcat_pkg::CHAN_W-1:0] : ch_ff;
      if (state_ff == mcat_pkg::ST_EXEC) begin
         mem_we          = (cmd_ff == mcat_pkg::CMD_CREATE) && ch_inside;
         mem_wa          = ch_ff;
         mem_wd.interval = ivl_ff;
         mem_wd.due_time = '0;
      end else begin
         mem_we          = s2_live;
         mem_wa          = s2_addr_ff;
         mem_wd.interval = s2_ivl_ff;
         mem_wd.due_time = s2_due_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[mem_ra];
   end

   // Remaining time of the addressed channel, saturated to 32 signed bits.
   assign left_diff = {1'b0, mem_q_ff.due_time} - {1'b0, sys_ff};

   always_comb begin
      if (!ch_valid) begin
         rsp_left_in = '0;
      end else if (left_diff[mcat_pkg::TIME_W] != left_diff[mcat_pkg::TIME_W-1]) begin
         rsp_left_in = left_diff[mcat_pkg::TIME_W] ? {1'b1, {(mcat_pkg::TIME_W-1){1'b0}}}
                                                   : {1'b0, {(mcat_pkg::TIME_W-1){1'b1}}};
      end else begin
         rsp_left_in = left_diff[mcat_pkg::TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= mcat_pkg::ST_IDLE;
         update_interval_ff <= mcat_pkg::UPDATE_INTERVAL_RESET;
         sys_ff             <= '0;
         pending_ff         <= '0;
         valid_ff           <= '0;
         enable_ff          <= '0;
         ack_ff             <= '0;
         alarm_ff           <= '0;
         scan_cnt_ff        <= '0;
         s1_vld_ff          <= 1'b0;
         s2_vld_ff          <= 1'b0;
         rebase_ff          <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sys_ff       <= sys_in;
         pending_ff   <= pending_in;
         valid_ff     <= valid_in;
         enable_ff    <= enable_in;
         ack_ff       <= ack_in;
         alarm_ff     <= alarm_in;
         scan_cnt_ff  <= scan_cnt_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s1_vld_ff;
         rebase_ff    <= rebase_in;
         rsp_valid_ff <= (state_ff == mcat_pkg::ST_REPORT);
         if (csr_wr_en) begin
            update_interval_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         ch_ff  <= req_channel;
         ivl_ff <= req_interval_ms;
         act_ff <= req_active_flag;
         el_ff  <= req_elapsed_ms;
      end
      if (state_ff == mcat_pkg::ST_EXEC) begin
         rebase_sub_ff <= sys_ff;
      end
      s1_addr_ff <= scan_cnt_ff[mcat_pkg::CHAN_W-1:0];
      s2_addr_ff <= s1_addr_ff;
      s2_ivl_ff  <= mem_q_ff.interval;
      s2_due_ff  <= s1_due;
      if (state_ff == mcat_pkg::ST_REPORT) begin
         rsp_mask_ff     <= valid_ff & alarm_ff;
         rsp_alarming_ff <= ch_valid && alarm_ff[ch_ff];
         rsp_active_ff   <= ch_valid && enable_ff[ch_ff];
         rsp_left_ff     <= rsp_left_in;
         rsp_sys_ff      <= sys_ff;
      end
   end

   assign busy              = (state_ff != mcat_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alarm_mask    = rsp_mask_ff;
   assign rsp_chan_alarming = rsp_alarming_ff;
   assign rsp_chan_active   = rsp_active_ff;
   assign rsp_time_left     = rsp_left_ff;
   assign rsp_system_time   = rsp_sys_ff;

endmodule
